FILE: hdl/rebq_pkg.sv
// ---------------------------------------------------------------------------
// rebq_pkg
// Shared types and constants for the rotary encoder and button qualifier.
// ---------------------------------------------------------------------------
`default_nettype none

package rebq_pkg;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic switch_raw;
    } t_in_word;

    typedef struct packed {
        logic signed [1:0]  step_dir;
        logic signed [15:0] position;
        logic               button_down;
        logic               press_event;
        logic               hold_event;
    } t_out_word;

    typedef struct packed {
        logic button_down;
        logic press_event;
        logic hold_event;
    } t_sw_flags;

    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_BWD  = 2'sb11;

    localparam logic [3:0] QC_FWD_0 = 4'b0001;
    localparam logic [3:0] QC_FWD_1 = 4'b0111;
    localparam logic [3:0] QC_FWD_2 = 4'b1110;
    localparam logic [3:0] QC_FWD_3 = 4'b1000;
    localparam logic [3:0] QC_BWD_0 = 4'b0010;
    localparam logic [3:0] QC_BWD_1 = 4'b0100;
    localparam logic [3:0] QC_BWD_2 = 4'b1101;
    localparam logic [3:0] QC_BWD_3 = 4'b1011;

    localparam logic       REG_DEBOUNCE = 1'b0;
    localparam logic       REG_HOLD     = 1'b1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [15:0] HOLD_RESET     = 16'd1000;

    function automatic logic signed [1:0] quad_dir(input logic [3:0] code);
        logic signed [1:0] d;
        case (code)
            QC_FWD_0, QC_FWD_1, QC_FWD_2, QC_FWD_3: d = DIR_FWD;
            QC_BWD_0, QC_BWD_1, QC_BWD_2, QC_BWD_3: d = DIR_BWD;
            default:                                d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rebq_quad.sv
// ---------------------------------------------------------------------------
// rebq_quad
// Quadrature decoder: previous/current AB pair to direction and position.
// ---------------------------------------------------------------------------
`default_nettype none

module rebq_quad
    import rebq_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_pin_a,
    input  wire logic               i_pin_b,
    output logic signed [1:0]       o_step_dir,
    output logic signed [15:0]      o_position
);

    localparam int EXT_W = (POSITION_WIDTH > 16) ? POSITION_WIDTH : 16;

    logic [1:0]                r_prev_ab;
    logic [POSITION_WIDTH-1:0] r_count;
    logic [1:0]                n_prev_ab;
    logic [POSITION_WIDTH-1:0] n_count;
    logic [EXT_W-1:0]          pos_ext;

    always_comb begin
        n_prev_ab  = {i_pin_a, i_pin_b};
        o_step_dir = quad_dir({r_prev_ab, n_prev_ab});
        n_count    = r_count + {{(POSITION_WIDTH-2){o_step_dir[1]}}, o_step_dir};
        pos_ext    = EXT_W'(n_count);
        o_position = pos_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab <= '0;
            r_count   <= '0;
        end else if (i_adv) begin
            r_prev_ab <= n_prev_ab;
            r_count   <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rebq_switch.sv
// ---------------------------------------------------------------------------
// rebq_switch
// Push switch debounce, press edge and one-shot hold timing.
// ---------------------------------------------------------------------------
`default_nettype none

module rebq_switch
    import rebq_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_switch_raw,
    input  wire logic [15:0] i_debounce_ticks,
    input  wire logic [15:0] i_hold_ticks,
    output t_sw_flags        o_flags
);

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    logic                   r_prev_raw;
    logic                   r_stable;
    logic [TIMER_WIDTH-1:0] r_quiet;
    logic                   r_hold_active;
    logic                   r_hold_fired;
    logic [TIMER_WIDTH-1:0] r_elapsed;

    logic                   n_stable;
    logic [TIMER_WIDTH-1:0] n_quiet;
    logic                   n_hold_active;
    logic                   n_hold_fired;
    logic [TIMER_WIDTH-1:0] n_elapsed;
    logic                   hold_ev;

    always_comb begin
        if (i_switch_raw != r_prev_raw) begin
            n_quiet = '0;
        end else if (r_quiet == '1) begin
            n_quiet = r_quiet;
        end else begin
            n_quiet = r_quiet + 1'b1;
        end

        if (CMP_W'(n_quiet) > CMP_W'(i_debounce_ticks)) begin
            n_stable = i_switch_raw;
        end else begin
            n_stable = r_stable;
        end

        n_hold_active = r_hold_active;
        n_hold_fired  = r_hold_fired;
        n_elapsed     = r_elapsed;
        hold_ev       = 1'b0;
        if (!i_switch_raw) begin
            if (!r_hold_active) begin
                n_hold_active = 1'b1;
                n_hold_fired  = 1'b0;
                n_elapsed     = '0;
            end else if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + 1'b1;
            end
            if (!n_hold_fired && (CMP_W'(n_elapsed) >= CMP_W'(i_hold_ticks))) begin
                n_hold_fired = 1'b1;
                hold_ev      = 1'b1;
            end
        end else begin
            n_hold_active = 1'b0;
            n_hold_fired  = 1'b0;
        end

        o_flags.button_down = !n_stable;
        o_flags.press_event = r_stable && !n_stable;
        o_flags.hold_event  = hold_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw    <= 1'b1;
            r_stable      <= 1'b1;
            r_quiet       <= '0;
            r_hold_active <= 1'b0;
            r_hold_fired  <= 1'b0;
            r_elapsed     <= '0;
        end else if (i_adv) begin
            r_prev_raw    <= i_switch_raw;
            r_stable      <= n_stable;
            r_quiet       <= n_quiet;
            r_hold_active <= n_hold_active;
            r_hold_fired  <= n_hold_fired;
            r_elapsed     <= n_elapsed;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rotary_encoder_button_qualifier.sv
// ---------------------------------------------------------------------------
// rotary_encoder_button_qualifier
// Quadrature decoder with debounced push switch, one sample word per tick while the output is not stalled.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Word
// in        input      i_in_valid / o_in_ready    t_in_word  i_in_data
// out       output     o_out_valid / i_out_ready  t_out_word o_out_data
// cfg       input      APB psel/penable/pready    32-bit, two registers
//
// A word accepted at a clock edge has its result registered at that same edge,
// and a new word is taken every cycle while i_out_ready is high.
// o_in_ready is high when the result register is empty or being drained.
// Synchronous active-low reset resets all state but the output data word; registers return to 50/1000.
// ---------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_button_qualifier
    import rebq_pkg::*;
#(
    parameter int POSITION_WIDTH = 16,
    parameter int TIMER_WIDTH    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_word    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_word        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0]       r_debounce;
    logic [15:0]       r_hold;
    logic              r_out_valid;
    t_out_word         r_out_data;
    t_out_word         n_out_data;

    logic              adv;
    logic              cfg_wr;
    logic signed [1:0] step_dir;
    logic [15:0]       position;
    t_sw_flags         sw_flags;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign prdata      = (paddr[2] == REG_HOLD) ? {16'd0, r_hold} : {16'd0, r_debounce};
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign adv         = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    rebq_quad #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_quad (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_pin_a    (i_in_data.pin_a),
        .i_pin_b    (i_in_data.pin_b),
        .o_step_dir (step_dir),
        .o_position (position)
    );

    rebq_switch #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_switch (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_switch_raw     (i_in_data.switch_raw),
        .i_debounce_ticks (r_debounce),
        .i_hold_ticks     (r_hold),
        .o_flags          (sw_flags)
    );

    always_comb begin
        n_out_data.step_dir    = step_dir;
        n_out_data.position    = position;
        n_out_data.button_down = sw_flags.button_down;
        n_out_data.press_event = sw_flags.press_event;
        n_out_data.hold_event  = sw_flags.hold_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_hold     <= HOLD_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_DEBOUNCE: r_debounce <= pwdata[15:0];
                REG_HOLD:     r_hold     <= pwdata[15:0];
                default:      r_hold     <= r_hold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire
